[hdl/bitmap_page_frame_allocator_top_assert.svh]
// Assertion macros for the page frame allocator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define BPFA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpfa assertion failed");
`define BPFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpfa assertion failed");
`else
`define BPFA_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define BPFA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/bpfa_pkg.sv]
// Shared constants, codes, types and helpers of the page frame allocator.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package bpfa_pkg;

  localparam int REGIONS               = 2;
  localparam int ZONE_BITS             = 64;
  localparam int MAX_FRAMES_PER_REGION = 65536;

  localparam int FRAME_W    = 40;
  localparam int COUNT_W    = 17;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int CFG_REGIONS = 2;

  localparam int BIT_W            = $clog2(ZONE_BITS);
  localparam int ZONES_PER_REGION = (MAX_FRAMES_PER_REGION + ZONE_BITS - 1) / ZONE_BITS;
  localparam int ZONE_W           = $clog2(ZONES_PER_REGION);
  localparam int IDX_W            = ZONE_W + BIT_W;
  localparam int SPAN_W           = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;
  localparam int REGION_W         = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int REGION_SLOTS     = 2 ** REGION_W;
  localparam int RCNT_W           = $clog2(REGIONS + 1);
  localparam int ADDR_W           = REGION_W + ZONE_W;
  localparam int RAM_DEPTH        = 2 ** ADDR_W;
  localparam int FRAME_CAP        = (MAX_FRAMES_PER_REGION < 2 ** COUNT_W) ?
                                    MAX_FRAMES_PER_REGION : 2 ** COUNT_W - 1;

  localparam logic [COUNT_W-1:0] MAX_FRAMES = COUNT_W'(FRAME_CAP);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_INIT  = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_R0_FIRST  = 3'd0,
    CFG_R0_FRAMES = 3'd1,
    CFG_R1_FIRST  = 3'd2,
    CFG_R1_FRAMES = 3'd3,
    CFG_RESERVED  = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_REGION,
    S_A_SCAN,
    S_A_PICK,
    S_A_COMMIT,
    S_F_REGION,
    S_F_UPDATE,
    S_I_PREP,
    S_I_SWEEP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    rgn_first;
    logic    rgn_next;
    logic    scan_start;
    logic    scan_check;
    logic    scan_next;
    logic    pick;
    logic    commit;
    logic    free_latch;
    logic    free_update;
    logic    prep;
    logic    sweep;
    logic    res_set;
    status_t res_status;
    logic    out_load;
  } bpfa_cmd_t;

  typedef struct packed {
    logic region_end;
    logic region_skip;
    logic scan_hit;
    logic scan_last;
    logic free_hit;
    logic sweep_last;
    logic out_free;
  } bpfa_stat_t;

  // ones in the low cnt bits, cnt saturating at a full zone
  function automatic logic [ZONE_BITS-1:0] low_mask(input logic [BIT_W:0] cnt);
    logic [ZONE_BITS-1:0] m;
    if (cnt >= (BIT_W+1)'(ZONE_BITS)) begin
      m = '1;
    end else begin
      m = (ZONE_BITS'(1) << cnt) - ZONE_BITS'(1);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

[hdl/bpfa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module bpfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/bpfa_ctrl.sv]
// Request sequencer of the page frame allocator.
// Depends on bpfa_pkg; drives the datapath through bpfa_cmd_t.
`default_nettype none
module bpfa_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bpfa_pkg::KIND_W-1:0] kind,
  input  bpfa_pkg::bpfa_stat_t        st,
  output bpfa_pkg::bpfa_cmd_t         cmd
);
  import bpfa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (st.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (kind)
            KIND_ALLOC: state_next = S_A_REGION;
            KIND_FREE:  state_next = S_F_REGION;
            KIND_INIT:  state_next = S_I_PREP;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_A_REGION: begin
        priority if (st.region_end) state_next = S_DONE;
        else if (!st.region_skip)   state_next = S_A_SCAN;
      end
      S_A_SCAN: begin
        priority if (st.scan_hit) state_next = S_A_PICK;
        else if (st.scan_last)    state_next = S_A_REGION;
      end
      S_A_PICK:   state_next = S_A_COMMIT;
      S_A_COMMIT: state_next = S_DONE;
      S_F_REGION: begin
        priority if (st.region_end) state_next = S_DONE;
        else if (st.free_hit)       state_next = S_F_UPDATE;
      end
      S_F_UPDATE: state_next = S_DONE;
      S_I_PREP: begin
        if (st.region_end) state_next = S_I_SWEEP;
      end
      S_I_SWEEP: begin
        if (st.sweep_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_CLEAR: cmd.sweep = 1'b1;
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept    = 1'b1;
          cmd.rgn_first = 1'b1;
          if (kind != KIND_ALLOC && kind != KIND_FREE && kind != KIND_INIT) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_DONE;
          end
        end
      end
      S_A_REGION: begin
        priority if (st.region_end) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NO_FRAME;
        end else if (st.region_skip) begin
          cmd.rgn_next = 1'b1;
        end else begin
          cmd.scan_start = 1'b1;
        end
      end
      S_A_SCAN: begin
        cmd.scan_check = 1'b1;
        priority if (st.scan_hit) begin
          cmd.scan_check = 1'b1;
        end else if (st.scan_last) begin
          cmd.rgn_next = 1'b1;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_A_PICK: cmd.pick = 1'b1;
      S_A_COMMIT: begin
        cmd.commit     = 1'b1;
        cmd.res_set    = 1'b1;
        cmd.res_status = ST_DONE;
      end
      S_F_REGION: begin
        priority if (st.region_end) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_BAD_FREE;
        end else if (st.free_hit) begin
          cmd.free_latch = 1'b1;
        end else begin
          cmd.rgn_next = 1'b1;
        end
      end
      S_F_UPDATE: begin
        cmd.free_update = 1'b1;
        cmd.res_set     = 1'b1;
        cmd.res_status  = ST_DONE;
      end
      S_I_PREP: begin
        if (!st.region_end) begin
          cmd.prep     = 1'b1;
          cmd.rgn_next = 1'b1;
        end
      end
      S_I_SWEEP: begin
        cmd.sweep = 1'b1;
        if (st.sweep_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_DONE;
        end
      end
      S_DONE: cmd.out_load = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[hdl/bpfa_dp.sv]
// Datapath of the page frame allocator: config registers, used counters,
// bitmap RAM, zone scan, bit pick and result register. Depends on bpfa_pkg, bpfa_ram.
`default_nettype none
`include "bitmap_page_frame_allocator_top_assert.svh"
module bpfa_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpfa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [bpfa_pkg::FRAME_W-1:0]    free_frame,
  input  bpfa_pkg::bpfa_cmd_t             cmd,
  output bpfa_pkg::bpfa_stat_t            st,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bpfa_pkg::STATUS_W-1:0]   status,
  output logic [bpfa_pkg::FRAME_W-1:0]    frame
);
  import bpfa_pkg::*;

  logic [FRAME_W-1:0]   cfg_first [CFG_REGIONS];
  logic [COUNT_W-1:0]   cfg_frames [CFG_REGIONS];
  logic [FRAME_W-1:0]   cfg_reserved;
  logic [COUNT_W-1:0]   used_count [REGION_SLOTS];

  logic [FRAME_W-1:0]   free_q;
  logic [RCNT_W-1:0]    rgn;
  logic [ZONE_W-1:0]    zone;
  logic [COUNT_W-1:0]   left;
  logic [ZONE_BITS-1:0] pick_word;
  logic [ZONE_BITS-1:0] pick_avail;
  logic [BIT_W-1:0]     pick_b;
  logic [BIT_W-1:0]     pick_b_next;
  logic [IDX_W-1:0]     idx_q;
  logic [ADDR_W-1:0]    sweep_addr;
  status_t              res_status;
  logic [FRAME_W-1:0]   res_frame;
  logic [STATUS_W-1:0]  out_status;
  logic [FRAME_W-1:0]   out_frame;

  logic [REGION_W-1:0]  rgn_idx;
  logic [FRAME_W-1:0]   lo_sel;
  logic [COUNT_W-1:0]   n_raw;
  logic [COUNT_W-1:0]   n_sel;
  logic [FRAME_W:0]     hi_sel;
  logic [FRAME_W-1:0]   lo_diff;
  logic [FRAME_W-1:0]   res_diff;
  logic [COUNT_W-1:0]   k_sel;
  logic [BIT_W:0]       scan_lim;
  logic [ZONE_BITS-1:0] avail;
  logic [ZONE_BITS-1:0] rdata;
  logic [ADDR_W-1:0]    raddr;
  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [ZONE_BITS-1:0] wr_data;
  logic [REGION_W-1:0]  sw_rgn;
  logic [SPAN_W-1:0]    sw_k;
  logic [SPAN_W-1:0]    sw_base;
  logic [SPAN_W-1:0]    sw_rem;
  logic [ZONE_BITS-1:0] sw_word;
  logic [ZONE_BITS-1:0] free_bit;

  assign rgn_idx = rgn[REGION_W-1:0];
  assign lo_sel  = cfg_first[rgn_idx];
  assign n_raw   = cfg_frames[rgn_idx];
  assign n_sel   = (n_raw > MAX_FRAMES) ? MAX_FRAMES : n_raw;
  assign hi_sel  = {1'b0, lo_sel} + (FRAME_W+1)'(n_sel);
  assign lo_diff = free_q - lo_sel;
  assign res_diff = cfg_reserved - lo_sel;

  always_comb begin
    priority if ({1'b0, cfg_reserved} >= hi_sel) begin
      k_sel = n_sel;
    end else if (cfg_reserved >= lo_sel) begin
      k_sel = res_diff[COUNT_W-1:0];
    end else begin
      k_sel = '0;
    end
  end

  // free bits of the current zone, limited to the region's frame count
  assign scan_lim = (left >= COUNT_W'(ZONE_BITS)) ? (BIT_W+1)'(ZONE_BITS) : left[BIT_W:0];
  assign avail    = ~rdata & low_mask(scan_lim);

  assign st.region_end  = (rgn == RCNT_W'(REGIONS));
  assign st.region_skip = (used_count[rgn_idx] == n_sel) || (n_sel == '0);
  assign st.scan_hit    = |avail;
  assign st.scan_last   = (left <= COUNT_W'(ZONE_BITS));
  assign st.free_hit    = (free_q >= lo_sel) && (lo_diff < FRAME_W'(n_sel));
  assign st.sweep_last  = &sweep_addr;
  assign st.out_free    = !out_valid || !out_stall;

  // initialize pattern: the low used_count frames of each region set
  assign sw_rgn  = sweep_addr[ADDR_W-1:ZONE_W];
  assign sw_k    = SPAN_W'(used_count[sw_rgn]);
  assign sw_base = SPAN_W'({sweep_addr[ZONE_W-1:0], {BIT_W{1'b0}}});
  assign sw_rem  = sw_k - sw_base;
  always_comb begin
    if (sw_k > sw_base) begin
      sw_word = low_mask((sw_rem >= SPAN_W'(ZONE_BITS)) ? (BIT_W+1)'(ZONE_BITS) :
                         sw_rem[BIT_W:0]);
    end else begin
      sw_word = '0;
    end
  end

  assign free_bit = ZONE_BITS'(1) << idx_q[BIT_W-1:0];

  always_comb begin
    priority if (cmd.scan_start) begin
      raddr = {rgn_idx, {ZONE_W{1'b0}}};
    end else if (cmd.free_latch) begin
      raddr = {rgn_idx, lo_diff[IDX_W-1:BIT_W]};
    end else begin
      raddr = {rgn_idx, zone + ZONE_W'(1)};
    end
  end

  always_comb begin
    we      = 1'b0;
    waddr   = {rgn_idx, zone};
    wr_data = pick_word | (ZONE_BITS'(1) << pick_b);
    priority if (cmd.sweep) begin
      we      = 1'b1;
      waddr   = sweep_addr;
      wr_data = sw_word;
    end else if (cmd.commit) begin
      we = 1'b1;
    end else if (cmd.free_update) begin
      we      = |(rdata & free_bit);
      waddr   = {rgn_idx, idx_q[IDX_W-1:BIT_W]};
      wr_data = rdata & ~free_bit;
    end
  end

  bpfa_ram #(
    .WIDTH (ZONE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    pick_b_next = '0;
    for (int i = ZONE_BITS - 1; i >= 0; i--) begin
      if (pick_avail[i]) pick_b_next = BIT_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_REGIONS; i++) begin
        cfg_first[i]  <= '0;
        cfg_frames[i] <= '0;
      end
      cfg_reserved <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_R0_FIRST:  cfg_first[0]  <= cfg_data[FRAME_W-1:0];
        CFG_R0_FRAMES: cfg_frames[0] <= cfg_data[COUNT_W-1:0];
        CFG_R1_FIRST:  cfg_first[1]  <= cfg_data[FRAME_W-1:0];
        CFG_R1_FRAMES: cfg_frames[1] <= cfg_data[COUNT_W-1:0];
        CFG_RESERVED:  cfg_reserved  <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REGION_SLOTS; i++) begin
        used_count[i] <= '0;
      end
    end else if (cmd.prep) begin
      used_count[rgn_idx] <= k_sel;
    end else if (cmd.commit) begin
      if (used_count[rgn_idx] != COUNT_MAX) begin
        used_count[rgn_idx] <= used_count[rgn_idx] + COUNT_W'(1);
      end
    end else if (cmd.free_update) begin
      if (|(rdata & free_bit) && used_count[rgn_idx] != '0) begin
        used_count[rgn_idx] <= used_count[rgn_idx] - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rgn        <= '0;
      sweep_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.rgn_first) begin
        rgn <= '0;
      end else if (cmd.rgn_next) begin
        rgn <= rgn + RCNT_W'(1);
      end
      if (cmd.sweep) begin
        sweep_addr <= sweep_addr + ADDR_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      free_q    <= free_frame;
      res_frame <= '0;
    end else if (cmd.commit) begin
      res_frame <= lo_sel + FRAME_W'({zone, pick_b});
    end
    if (cmd.scan_start) begin
      zone <= '0;
      left <= n_sel;
    end else if (cmd.scan_next) begin
      zone <= zone + ZONE_W'(1);
      left <= left - COUNT_W'(ZONE_BITS);
    end
    if (cmd.scan_check) begin
      pick_word  <= rdata;
      pick_avail <= avail;
    end
    if (cmd.pick) begin
      pick_b <= pick_b_next;
    end
    if (cmd.free_latch) begin
      idx_q <= lo_diff[IDX_W-1:0];
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_frame  <= res_frame;
    end
  end

  assign status = out_status;
  assign frame  = out_frame;

  `BPFA_ASSERT_IMPL(a_load_when_free, clk, rst, cmd.out_load, !out_valid || !out_stall)
  `BPFA_ASSERT_IMPL(a_commit_one_bit, clk, rst, cmd.commit, $onehot(wr_data ^ pick_word))
  `BPFA_ASSERT_IMPL(a_commit_free_bit, clk, rst, cmd.commit, pick_avail[pick_b])
  `BPFA_ASSERT_IMPL(a_fail_no_frame, clk, rst, cmd.out_load && res_status != ST_DONE, res_frame == '0)

endmodule
`default_nettype wire

[hdl/bitmap_page_frame_allocator_top.sv]
// Top level of the first-fit bitmap page frame allocator.
// Depends on bpfa_pkg, bpfa_ctrl, bpfa_dp (which holds bpfa_ram).
//
// One request at a time, one result per request, held in an output register
// so the next request is taken while the result waits. After reset the
// bitmap memory (REGIONS x 1024 zone words) is cleared word by word
// before the first request is taken. Allocate visits the regions in order,
// reads the zone words of a region one by one until a free bit is found,
// then picks the lowest free bit and commits it; full regions are skipped
// by their used counter. Free finds the region that holds the frame and
// clears its bit. Initialize sets the used counter of each region, then
// rewrites every word through the single write port of the bitmap memory.
// The unused kind goes straight to the result. Configuration writes are
// always taken.
`default_nettype none
module bitmap_page_frame_allocator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpfa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bpfa_pkg::KIND_W-1:0]     kind,
  input  logic [bpfa_pkg::FRAME_W-1:0]    free_frame,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bpfa_pkg::STATUS_W-1:0]   status,
  output logic [bpfa_pkg::FRAME_W-1:0]    frame
);
  import bpfa_pkg::*;

  bpfa_cmd_t  cmd;
  bpfa_stat_t st;

  assign cfg_ready = 1'b1;

  bpfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .st       (st),
    .cmd      (cmd)
  );

  bpfa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .free_frame (free_frame),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .frame      (frame)
  );

endmodule
`default_nettype wire
